// ===== rtl/lkcd_pkg.sv =====
// Shared constants, types and arithmetic helpers for the leg kinematics and
// contact detection block. No dependencies; every file but lkcd_if imports it.
`default_nettype none

package lkcd_pkg;

   localparam int NUM_LEGS = 4;

   // Configuration port geometry.
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_HIP_LENGTH    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_THIGH_LENGTH  = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_CALF_LENGTH   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FOOT_LENGTH   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_EFFORT_THR    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CROUCH_FLOOR  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_CROUCH_DEPTH  = 3'd6;

   localparam logic [15:0] HIP_LENGTH_RST    = 16'd6160;
   localparam logic [15:0] THIGH_LENGTH_RST  = 16'd13926;
   localparam logic [15:0] CALF_LENGTH_RST   = 16'd13926;
   localparam logic [15:0] FOOT_LENGTH_RST   = 16'd0;
   localparam logic [14:0] EFFORT_THR_RST    = 15'd5120;
   localparam logic [14:0] CROUCH_FLOOR_RST  = 15'd2560;
   localparam logic [15:0] CROUCH_DEPTH_RST  = 16'd7864;

   // Datapath widths.
   localparam int TRIG_W = 20;
   localparam int AB_W = 22;
   localparam int HT_W = 20;
   localparam int COEF_W = 24;
   localparam int PROD_W = 40;
   localparam int POS_W = 18;
   localparam int VEL_W = 24;
   localparam int WIDE_W = 48;

   localparam int CORDIC_STEPS = 16;
   localparam int STEPS_PER_STAGE = 4;
   localparam int CORDIC_STAGES = CORDIC_STEPS / STEPS_PER_STAGE;

   localparam logic signed [TRIG_W-1:0] PI_Q16 = 20'sd205887;
   localparam logic signed [TRIG_W-1:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_Q16 = 20'sd39797;

   typedef struct packed {
      logic [15:0] hip_length;
      logic [15:0] thigh_length;
      logic [15:0] calf_length;
      logic [15:0] foot_length;
      logic [14:0] effort_threshold;
      logic [14:0] crouch_effort_floor;
      logic [15:0] crouch_depth;
   } cfg_type;

   // Fields that ride along the pipeline untouched until they are needed.
   typedef struct packed {
      logic [1:0]         leg;
      logic signed [15:0] hip_rate;
      logic signed [15:0] thigh_rate;
      logic signed [15:0] knee_rate;
      logic signed [15:0] foot_effort;
   } side_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [TRIG_W-1:0] z;
   } rot_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] s1;
      logic signed [TRIG_W-1:0] c1;
      logic signed [TRIG_W-1:0] s2;
      logic signed [TRIG_W-1:0] c2;
      logic signed [TRIG_W-1:0] s3;
      logic signed [TRIG_W-1:0] c3;
   } trig_type;

   // Rate products and saturated position leaving the kinematics pipeline.
   typedef struct packed {
      logic signed [PROD_W-1:0] x2;
      logic signed [PROD_W-1:0] x3;
      logic signed [PROD_W-1:0] y1;
      logic signed [PROD_W-1:0] y2;
      logic signed [PROD_W-1:0] y3;
      logic signed [PROD_W-1:0] z1;
      logic signed [PROD_W-1:0] z2;
      logic signed [PROD_W-1:0] z3;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
   } prod_type;

   function automatic logic signed [TRIG_W-1:0] atan_q16(input logic [3:0] i);
      logic signed [TRIG_W-1:0] a;
      unique case (i)
         4'd0:  a = 20'sd51472;
         4'd1:  a = 20'sd30385;
         4'd2:  a = 20'sd16055;
         4'd3:  a = 20'sd8150;
         4'd4:  a = 20'sd4091;
         4'd5:  a = 20'sd2047;
         4'd6:  a = 20'sd1024;
         4'd7:  a = 20'sd512;
         4'd8:  a = 20'sd256;
         4'd9:  a = 20'sd128;
         4'd10: a = 20'sd64;
         4'd11: a = 20'sd32;
         4'd12: a = 20'sd16;
         4'd13: a = 20'sd8;
         4'd14: a = 20'sd4;
         4'd15: a = 20'sd2;
      endcase
      return a;
   endfunction

   function automatic rot_type cordic_step(input rot_type r, input int i);
      rot_type o;
      if (!r.z[TRIG_W-1]) begin
         o.x = r.x - (r.y >>> i);
         o.y = r.y + (r.x >>> i);
         o.z = r.z - atan_q16(4'(i));
      end else begin
         o.x = r.x + (r.y >>> i);
         o.y = r.y - (r.x >>> i);
         o.z = r.z + atan_q16(4'(i));
      end
      return o;
   endfunction

   // Round a product of two Q16 values back to Q16.
   function automatic logic signed [31:0] rnd16(input logic signed [WIDE_W-1:0] p);
      logic signed [WIDE_W-1:0] t;
      t = p + 48'sd32768;
      return t[WIDE_W-1:16];
   endfunction

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
      logic signed [POS_W-1:0] r;
      if (v > 48'sd131071) begin
         r = 18'sd131071;
      end else if (v < -48'sd131072) begin
         r = -18'sd131072;
      end else begin
         r = v[POS_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [WIDE_W-1:0] v);
      logic signed [VEL_W-1:0] r;
      if (v > 48'sd8388607) begin
         r = 24'sd8388607;
      end else if (v < -48'sd8388608) begin
         r = -24'sd8388608;
      end else begin
         r = v[VEL_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/lkcd_if.sv =====
// Valid/ready channel interfaces for the joint sample input and the foot
// state result. Depend on nothing but plain logic.
`default_nettype none

interface lkcd_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         leg;
   logic signed [15:0] hip_angle;
   logic signed [15:0] thigh_angle;
   logic signed [15:0] knee_angle;
   logic signed [15:0] hip_rate;
   logic signed [15:0] thigh_rate;
   logic signed [15:0] knee_rate;
   logic signed [15:0] foot_effort;

   modport source (output valid, leg, hip_angle, thigh_angle, knee_angle,
                   hip_rate, thigh_rate, knee_rate, foot_effort, input ready);
   modport sink (input valid, leg, hip_angle, thigh_angle, knee_angle,
                 hip_rate, thigh_rate, knee_rate, foot_effort, output ready);
endinterface

interface lkcd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] pos_x;
   logic signed [17:0] pos_y;
   logic signed [17:0] pos_z;
   logic signed [23:0] vel_x;
   logic signed [23:0] vel_y;
   logic signed [23:0] vel_z;
   logic               in_contact;
   logic               landing;

   modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                   in_contact, landing, input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 in_contact, landing, output ready);
endinterface

`default_nettype wire

// ===== rtl/lkcd_cordic.sv =====
// Pipelined CORDIC that turns the three joint angles into sine and cosine.
// Depends on lkcd_pkg for the step function, arctangent table and types.
`default_nettype none

module lkcd_cordic (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output logic                           in_ready,
   input  wire logic signed [15:0]        hip_angle,
   input  wire logic signed [15:0]        thigh_angle,
   input  wire logic signed [15:0]        knee_angle,
   input  wire lkcd_pkg::side_type        in_side,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output lkcd_pkg::trig_type             out_trig,
   output lkcd_pkg::side_type             out_side
);
   import lkcd_pkg::*;

   logic signed [15:0]       ang [3];
   rot_type                  seed [3];
   logic                     seed_flip [3];
   rot_type                  rot_in [CORDIC_STAGES][3];
   rot_type                  rot_ff [CORDIC_STAGES][3];
   logic                     flip_ff [CORDIC_STAGES][3];
   side_type                 side_ff [CORDIC_STAGES];
   logic [CORDIC_STAGES-1:0] valid_ff;
   logic [CORDIC_STAGES-1:0] en;

   assign ang[0] = hip_angle;
   assign ang[1] = thigh_angle;
   assign ang[2] = knee_angle;

   // Q3.13 angle widened to Q16 and folded once by pi into the CORDIC range.
   always_comb begin
      logic signed [TRIG_W-1:0] z;
      for (int j = 0; j < 3; j++) begin
         z = TRIG_W'($signed({ang[j], 3'b000}));
         seed_flip[j] = 1'b0;
         if (z > HALF_PI_Q16) begin
            z = z - PI_Q16;
            seed_flip[j] = 1'b1;
         end else if (z < -HALF_PI_Q16) begin
            z = z + PI_Q16;
            seed_flip[j] = 1'b1;
         end
         seed[j].x = CORDIC_GAIN_Q16;
         seed[j].y = '0;
         seed[j].z = z;
      end
   end

   always_comb begin
      rot_type r;
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         for (int j = 0; j < 3; j++) begin
            r = (k == 0) ? seed[j] : rot_ff[k-1][j];
            for (int s = 0; s < STEPS_PER_STAGE; s++) begin
               r = cordic_step(r, k * STEPS_PER_STAGE + s);
            end
            rot_in[k][j] = r;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         if (k == CORDIC_STAGES - 1) begin
            en[k] = !valid_ff[k] || out_ready;
         end else begin
            en[k] = !valid_ff[k] || en[k+1];
         end
      end
   end

   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < CORDIC_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= (k == 0) ? in_valid : valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < CORDIC_STAGES; k++) begin
         if (en[k]) begin
            side_ff[k] <= (k == 0) ? in_side : side_ff[k-1];
            for (int j = 0; j < 3; j++) begin
               rot_ff[k][j]  <= rot_in[k][j];
               flip_ff[k][j] <= (k == 0) ? seed_flip[j] : flip_ff[k-1][j];
            end
         end
      end
   end

   localparam int LAST = CORDIC_STAGES - 1;

   always_comb begin
      out_trig.s1 = flip_ff[LAST][0] ? -rot_ff[LAST][0].y : rot_ff[LAST][0].y;
      out_trig.c1 = flip_ff[LAST][0] ? -rot_ff[LAST][0].x : rot_ff[LAST][0].x;
      out_trig.s2 = flip_ff[LAST][1] ? -rot_ff[LAST][1].y : rot_ff[LAST][1].y;
      out_trig.c2 = flip_ff[LAST][1] ? -rot_ff[LAST][1].x : rot_ff[LAST][1].x;
      out_trig.s3 = flip_ff[LAST][2] ? -rot_ff[LAST][2].y : rot_ff[LAST][2].y;
      out_trig.c3 = flip_ff[LAST][2] ? -rot_ff[LAST][2].x : rot_ff[LAST][2].x;
   end

   assign out_valid = valid_ff[LAST];
   assign out_side  = side_ff[LAST];

endmodule

`default_nettype wire

// ===== rtl/lkcd_kin.sv =====
// Four-stage forward kinematics and Jacobian datapath: trig products, link
// terms, position and velocity coefficients, rate products. Uses lkcd_pkg.
`default_nettype none

module lkcd_kin (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lkcd_pkg::cfg_type    cfg,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire lkcd_pkg::trig_type   in_trig,
   input  wire lkcd_pkg::side_type   in_side,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output lkcd_pkg::prod_type        out_prod,
   output lkcd_pkg::side_type        out_side
);
   import lkcd_pkg::*;

   logic [3:0] valid_ff;
   logic [3:0] en;
   side_type   side_ff [4];

   // Stage 1: compound angle terms.
   trig_type                 trig1_ff;
   logic signed [TRIG_W-1:0] c23_ff, c23_in, s23_ff, s23_in;

   // Stage 2: link projections and hip terms.
   logic signed [TRIG_W-1:0] s1_2_ff, c1_2_ff;
   logic signed [AB_W-1:0]   ab_ff, ab_in, cd_ff, cd_in, a_ff, a_in, c_ff, c_in;
   logic signed [HT_W-1:0]   hc1_ff, hc1_in, hs1_ff, hs1_in;

   // Stage 3: saturated position and velocity coefficients.
   logic signed [POS_W-1:0]  px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [COEF_W-1:0] kab_ff, ka_ff;
   logic signed [COEF_W-1:0] ky1_ff, ky1_in, ky2_ff, ky2_in, ky3_ff, ky3_in;
   logic signed [COEF_W-1:0] kz1_ff, kz1_in, kz2_ff, kz2_in, kz3_ff, kz3_in;

   // Stage 4: coefficient times joint rate.
   prod_type prod_ff, prod_in;

   always_comb begin
      en[3] = !valid_ff[3] || out_ready;
      en[2] = !valid_ff[2] || en[3];
      en[1] = !valid_ff[1] || en[2];
      en[0] = !valid_ff[0] || en[1];
   end

   assign in_ready = en[0];

   always_comb begin
      logic signed [WIDE_W-1:0] p_cc, p_ss, p_sc, p_cs;
      p_cc = in_trig.c2 * in_trig.c3;
      p_ss = in_trig.s2 * in_trig.s3;
      p_sc = in_trig.s2 * in_trig.c3;
      p_cs = in_trig.c2 * in_trig.s3;
      c23_in = TRIG_W'(rnd16(p_cc) - rnd16(p_ss));
      s23_in = TRIG_W'(rnd16(p_sc) + rnd16(p_cs));
   end

   always_comb begin
      logic [16:0]              l_sum;
      logic signed [17:0]       l_s;
      logic signed [16:0]       t_s;
      logic signed [17:0]       hip_s;
      logic signed [17:0]       h_s;
      logic signed [31:0]       a_r, b_r, c_r, d_r;
      l_sum = 17'(cfg.calf_length) + 17'(cfg.foot_length);
      l_s   = $signed({1'b0, l_sum});
      t_s   = $signed({1'b0, cfg.thigh_length});
      hip_s = $signed({2'b00, cfg.hip_length});
      h_s   = (side_ff[0].leg == 2'd1 || side_ff[0].leg == 2'd2) ? hip_s : -hip_s;
      a_r = rnd16(WIDE_W'(l_s * c23_ff));
      b_r = rnd16(WIDE_W'(t_s * trig1_ff.c2));
      c_r = rnd16(WIDE_W'(l_s * s23_ff));
      d_r = rnd16(WIDE_W'(t_s * trig1_ff.s2));
      a_in   = AB_W'(a_r);
      c_in   = AB_W'(c_r);
      ab_in  = AB_W'(a_r + b_r);
      cd_in  = AB_W'(c_r + d_r);
      hc1_in = HT_W'(rnd16(WIDE_W'(h_s * trig1_ff.c1)));
      hs1_in = HT_W'(rnd16(WIDE_W'(h_s * trig1_ff.s1)));
   end

   always_comb begin
      logic signed [31:0] s1ab, c1ab, s1cd, c1cd, s1c, c1c;
      s1ab = rnd16(WIDE_W'(s1_2_ff * ab_ff));
      c1ab = rnd16(WIDE_W'(c1_2_ff * ab_ff));
      s1cd = rnd16(WIDE_W'(s1_2_ff * cd_ff));
      c1cd = rnd16(WIDE_W'(c1_2_ff * cd_ff));
      s1c  = rnd16(WIDE_W'(s1_2_ff * c_ff));
      c1c  = rnd16(WIDE_W'(c1_2_ff * c_ff));
      px_in  = sat_pos(-WIDE_W'(cd_ff));
      py_in  = sat_pos(WIDE_W'(hc1_ff) + WIDE_W'(s1ab));
      pz_in  = sat_pos(WIDE_W'(hs1_ff) - WIDE_W'(c1ab));
      ky1_in = COEF_W'(c1ab - 32'(hs1_ff));
      ky2_in = COEF_W'(s1cd);
      ky3_in = COEF_W'(s1c);
      kz1_in = COEF_W'(s1ab + 32'(hc1_ff));
      kz2_in = COEF_W'(c1cd);
      kz3_in = COEF_W'(c1c);
   end

   always_comb begin
      prod_in.x2 = PROD_W'(kab_ff * side_ff[2].thigh_rate);
      prod_in.x3 = PROD_W'(ka_ff * side_ff[2].knee_rate);
      prod_in.y1 = PROD_W'(ky1_ff * side_ff[2].hip_rate);
      prod_in.y2 = PROD_W'(ky2_ff * side_ff[2].thigh_rate);
      prod_in.y3 = PROD_W'(ky3_ff * side_ff[2].knee_rate);
      prod_in.z1 = PROD_W'(kz1_ff * side_ff[2].hip_rate);
      prod_in.z2 = PROD_W'(kz2_ff * side_ff[2].thigh_rate);
      prod_in.z3 = PROD_W'(kz3_ff * side_ff[2].knee_rate);
      prod_in.pos_x = px_ff;
      prod_in.pos_y = py_ff;
      prod_in.pos_z = pz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < 4; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         side_ff[0] <= in_side;
         trig1_ff   <= in_trig;
         c23_ff     <= c23_in;
         s23_ff     <= s23_in;
      end
      if (en[1]) begin
         side_ff[1] <= side_ff[0];
         s1_2_ff    <= trig1_ff.s1;
         c1_2_ff    <= trig1_ff.c1;
         ab_ff      <= ab_in;
         cd_ff      <= cd_in;
         a_ff       <= a_in;
         c_ff       <= c_in;
         hc1_ff     <= hc1_in;
         hs1_ff     <= hs1_in;
      end
      if (en[2]) begin
         side_ff[2] <= side_ff[1];
         px_ff      <= px_in;
         py_ff      <= py_in;
         pz_ff      <= pz_in;
         kab_ff     <= COEF_W'(ab_ff);
         ka_ff      <= COEF_W'(a_ff);
         ky1_ff     <= ky1_in;
         ky2_ff     <= ky2_in;
         ky3_ff     <= ky3_in;
         kz1_ff     <= kz1_in;
         kz2_ff     <= kz2_in;
         kz3_ff     <= kz3_in;
      end
      if (en[3]) begin
         side_ff[3] <= side_ff[2];
         prod_ff    <= prod_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_prod  = prod_ff;
   assign out_side  = side_ff[3];

endmodule

`default_nettype wire

// ===== rtl/leg_kinematics_contact_detect_unit.sv =====
// Leg kinematics and contact detection: takes one beat of joint angles, rates
// and foot effort per clock unless stalled, and returns foot position, velocity
// and contact flags. The pipeline is a four-stage CORDIC followed by four
// multiplier stages and a registered output stage; one beat per cycle is
// sustained while the receiver keeps up. Every stage holds its own valid bit
// and only stalls when the stage after it is full, so an input beat is still
// taken while a result waits in the output register as long as a bubble lies
// somewhere in the pipeline. The per-leg contact history is read and written
// in the output stage, so consecutive beats for the same leg see each other
// in order. Depends on lkcd_pkg, lkcd_if, lkcd_cordic and lkcd_kin.
`default_nettype none

module leg_kinematics_contact_detect_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   lkcd_req_if.sink                          req_chan,
   lkcd_rsp_if.source                        rsp_chan,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [lkcd_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [lkcd_pkg::DATA_W-1:0]  pwdata,
   output logic [lkcd_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import lkcd_pkg::*;

   cfg_type              cfg_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 cfg_wr;

   side_type in_side;
   logic     cor_valid, cor_ready;
   trig_type cor_trig;
   side_type cor_side;
   logic     kin_valid, kin_ready;
   prod_type kin_prod;
   side_type kin_side;

   logic                    out_en;
   logic                    rsp_valid_ff;
   logic signed [POS_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [VEL_W-1:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in, vel_z_ff, vel_z_in;
   logic                    contact_ff, contact_in, landing_ff, landing_in;
   logic [NUM_LEGS-1:0]     was_ff;
   logic                    leg_ok;

   // Register file.
   assign reg_idx = paddr[ADDR_W-1:2];
   assign cfg_wr  = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hip_length          <= HIP_LENGTH_RST;
         cfg_ff.thigh_length        <= THIGH_LENGTH_RST;
         cfg_ff.calf_length         <= CALF_LENGTH_RST;
         cfg_ff.foot_length         <= FOOT_LENGTH_RST;
         cfg_ff.effort_threshold    <= EFFORT_THR_RST;
         cfg_ff.crouch_effort_floor <= CROUCH_FLOOR_RST;
         cfg_ff.crouch_depth        <= CROUCH_DEPTH_RST;
      end else if (cfg_wr) begin
         unique case (reg_idx)
            REG_HIP_LENGTH:   cfg_ff.hip_length          <= pwdata[15:0];
            REG_THIGH_LENGTH: cfg_ff.thigh_length        <= pwdata[15:0];
            REG_CALF_LENGTH:  cfg_ff.calf_length         <= pwdata[15:0];
            REG_FOOT_LENGTH:  cfg_ff.foot_length         <= pwdata[15:0];
            REG_EFFORT_THR:   cfg_ff.effort_threshold    <= pwdata[14:0];
            REG_CROUCH_FLOOR: cfg_ff.crouch_effort_floor <= pwdata[14:0];
            REG_CROUCH_DEPTH: cfg_ff.crouch_depth        <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_HIP_LENGTH:   prdata = DATA_W'(cfg_ff.hip_length);
         REG_THIGH_LENGTH: prdata = DATA_W'(cfg_ff.thigh_length);
         REG_CALF_LENGTH:  prdata = DATA_W'(cfg_ff.calf_length);
         REG_FOOT_LENGTH:  prdata = DATA_W'(cfg_ff.foot_length);
         REG_EFFORT_THR:   prdata = DATA_W'(cfg_ff.effort_threshold);
         REG_CROUCH_FLOOR: prdata = DATA_W'(cfg_ff.crouch_effort_floor);
         REG_CROUCH_DEPTH: prdata = DATA_W'(cfg_ff.crouch_depth);
         default:          prdata = '0;
      endcase
   end

   assign in_side.leg         = req_chan.leg;
   assign in_side.hip_rate    = req_chan.hip_rate;
   assign in_side.thigh_rate  = req_chan.thigh_rate;
   assign in_side.knee_rate   = req_chan.knee_rate;
   assign in_side.foot_effort = req_chan.foot_effort;

   lkcd_cordic u_cordic (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .hip_angle   (req_chan.hip_angle),
      .thigh_angle (req_chan.thigh_angle),
      .knee_angle  (req_chan.knee_angle),
      .in_side     (in_side),
      .out_valid   (cor_valid),
      .out_ready   (cor_ready),
      .out_trig    (cor_trig),
      .out_side    (cor_side)
   );

   lkcd_kin u_kin (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (cor_valid),
      .in_ready  (cor_ready),
      .in_trig   (cor_trig),
      .in_side   (cor_side),
      .out_valid (kin_valid),
      .out_ready (out_en),
      .out_prod  (kin_prod),
      .out_side  (kin_side)
   );

   assign out_en = !rsp_valid_ff || rsp_chan.ready;
   assign leg_ok = int'(kin_side.leg) < NUM_LEGS;

   // Velocity sums rounded from Q26 to Q16, then contact decision.
   always_comb begin
      logic signed [WIDE_W-1:0] sx, sy, sz;
      logic signed [WIDE_W-1:0] vx;
      logic signed [16:0]       eff_s, thr_s, floor_s;
      logic signed [18:0]       zsum;
      logic                     prev, hard;
      sx = WIDE_W'(kin_prod.x2) + WIDE_W'(kin_prod.x3) + 48'sd512;
      sy = WIDE_W'(kin_prod.y1) - WIDE_W'(kin_prod.y2) - WIDE_W'(kin_prod.y3) + 48'sd512;
      sz = WIDE_W'(kin_prod.z1) + WIDE_W'(kin_prod.z2) + WIDE_W'(kin_prod.z3) + 48'sd512;
      vx = sx >>> 10;
      vel_x_in = sat_vel(-vx);
      vel_y_in = sat_vel(sy >>> 10);
      vel_z_in = sat_vel(sz >>> 10);
      eff_s   = 17'(kin_side.foot_effort);
      thr_s   = $signed({2'b00, cfg_ff.effort_threshold});
      floor_s = $signed({2'b00, cfg_ff.crouch_effort_floor});
      zsum    = 19'(kin_prod.pos_z) + $signed({3'b000, cfg_ff.crouch_depth});
      prev    = leg_ok && was_ff[kin_side.leg];
      hard    = eff_s >= thr_s;
      landing_in = hard && !prev;
      // Crouch window: moderate effort with the foot just below the hip.
      contact_in = hard || ((eff_s > floor_s) && (eff_s < thr_s) &&
                            kin_prod.pos_z[POS_W-1] && (zsum > 19'sd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         was_ff       <= '0;
      end else if (out_en) begin
         rsp_valid_ff <= kin_valid;
         if (kin_valid && leg_ok) begin
            was_ff[kin_side.leg] <= contact_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         pos_x_ff   <= kin_prod.pos_x;
         pos_y_ff   <= kin_prod.pos_y;
         pos_z_ff   <= kin_prod.pos_z;
         vel_x_ff   <= vel_x_in;
         vel_y_ff   <= vel_y_in;
         vel_z_ff   <= vel_z_in;
         contact_ff <= contact_in;
         landing_ff <= landing_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.pos_x      = pos_x_ff;
   assign rsp_chan.pos_y      = pos_y_ff;
   assign rsp_chan.pos_z      = pos_z_ff;
   assign rsp_chan.vel_x      = vel_x_ff;
   assign rsp_chan.vel_y      = vel_y_ff;
   assign rsp_chan.vel_z      = vel_z_ff;
   assign rsp_chan.in_contact = contact_ff;
   assign rsp_chan.landing    = landing_ff;

`ifndef NO_ASSERTIONS
   a_landing_has_contact: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && landing_ff) |-> contact_ff)
      else $error("landing flagged without contact");

   a_history_update: assert property (@(posedge clock) disable iff (reset)
      (out_en && kin_valid && leg_ok) |=> (was_ff[$past(kin_side.leg)] == $past(contact_in)))
      else $error("contact history not updated for delivered beat");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (was_ff == '0) && !rsp_valid_ff)
      else $error("reset left contact history or output valid set");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/lkcd_foot_state_checker.sv =====
// Watches the joint sample channel, the foot state channel and the register port,
// predicts each foot state result and compares it with what the block returns.
// Depends on lkcd_pkg and the channel interfaces in lkcd_if.
`default_nettype none

module lkcd_foot_state_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   lkcd_req_if                               req_mon,
   lkcd_rsp_if                               rsp_mon,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic                         pready,
   input  wire logic [lkcd_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [lkcd_pkg::DATA_W-1:0]  pwdata,
   output int                                mismatches,
   output int                                outstanding,
   output int                                results_seen,
   output int                                contacts_seen,
   output int                                landings_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import lkcd_pkg::*;

   typedef struct packed {
      logic signed [17:0] pos_x;
      logic signed [17:0] pos_y;
      logic signed [17:0] pos_z;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic signed [23:0] vel_z;
      logic               in_contact;
      logic               landing;
   } foot_state_type;

   localparam longint ATAN_Q16 [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                        256, 128, 64, 32, 16, 8, 4, 2};

   cfg_type        geom;
   logic [3:0]     leg_contact;
   foot_state_type foot_state_q[$];

   function automatic longint qmul(input longint a, input longint b);
      return (a * b + 32768) >>> 16;
   endfunction

   function automatic longint clamp(input longint v, input int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
   endfunction

   function automatic void joint_sincos(input logic signed [15:0] ang,
                                        output longint s, output longint c);
      longint z, x, y, nx;
      logic   flip;
      z = longint'(ang) * 8;
      x = 39797;
      y = 0;
      flip = 1'b0;
      // Fold the angle by pi into the CORDIC range and negate the pair afterwards.
      if (z > 102944) begin
         z -= 205887;
         flip = 1'b1;
      end else if (z < -102944) begin
         z += 205887;
         flip = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= ATAN_Q16[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += ATAN_Q16[i];
         end
         x = nx;
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic foot_state_type predict_foot_state();
      foot_state_type r;
      longint s1, c1, s2, c2, s3, c3, c23, s23, len_l, len_t, len_h;
      longint a, b, cc, d, ab, cd, px, py, pz, vx, vy, vz;
      longint dq1, dq2, dq3, eff, thr;
      logic   contact, prev;
      joint_sincos(req_mon.hip_angle, s1, c1);
      joint_sincos(req_mon.thigh_angle, s2, c2);
      joint_sincos(req_mon.knee_angle, s3, c3);
      dq1 = req_mon.hip_rate;
      dq2 = req_mon.thigh_rate;
      dq3 = req_mon.knee_rate;
      eff = req_mon.foot_effort;
      thr = longint'(geom.effort_threshold);
      len_l = longint'(geom.calf_length) + longint'(geom.foot_length);
      len_t = longint'(geom.thigh_length);
      len_h = (req_mon.leg == 2'd1 || req_mon.leg == 2'd2) ? longint'(geom.hip_length)
                                                           : -longint'(geom.hip_length);
      c23 = qmul(c2, c3) - qmul(s2, s3);
      s23 = qmul(s2, c3) + qmul(c2, s3);
      a = qmul(len_l, c23);
      b = qmul(len_t, c2);
      cc = qmul(len_l, s23);
      d = qmul(len_t, s2);
      ab = a + b;
      cd = cc + d;
      px = clamp(-cd, 18);
      py = clamp(qmul(len_h, c1) + qmul(s1, ab), 18);
      pz = clamp(qmul(len_h, s1) - qmul(c1, ab), 18);
      vx = clamp(-((ab * dq2 + a * dq3 + 512) >>> 10), 24);
      vy = clamp(((qmul(c1, ab) - qmul(len_h, s1)) * dq1 - qmul(s1, cd) * dq2
                  - qmul(s1, cc) * dq3 + 512) >>> 10, 24);
      vz = clamp(((qmul(s1, ab) + qmul(len_h, c1)) * dq1 + qmul(c1, cd) * dq2
                  + qmul(c1, cc) * dq3 + 512) >>> 10, 24);
      prev = leg_contact[req_mon.leg];
      contact = eff >= thr;
      r.landing = contact && !prev;
      // A moderate effort with the foot just below the hip still counts as contact.
      if (eff > longint'(geom.crouch_effort_floor) && eff < thr && pz < 0
          && pz > -longint'(geom.crouch_depth)) begin
         contact = 1'b1;
      end
      leg_contact[req_mon.leg] = contact;
      r.pos_x = px[17:0];
      r.pos_y = py[17:0];
      r.pos_z = pz[17:0];
      r.vel_x = vx[23:0];
      r.vel_y = vy[23:0];
      r.vel_z = vz[23:0];
      r.in_contact = contact;
      return r;
   endfunction

   assign outstanding = foot_state_q.size();

   always @(posedge clock) begin
      foot_state_type want, got;
      if (reset) begin
         geom <= '{HIP_LENGTH_RST, THIGH_LENGTH_RST, CALF_LENGTH_RST, FOOT_LENGTH_RST,
                   EFFORT_THR_RST, CROUCH_FLOOR_RST, CROUCH_DEPTH_RST};
         leg_contact = '0;
         foot_state_q.delete();
         mismatches <= 0;
         results_seen <= 0;
         contacts_seen <= 0;
         landings_seen <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_HIP_LENGTH:   geom.hip_length <= pwdata[15:0];
               REG_THIGH_LENGTH: geom.thigh_length <= pwdata[15:0];
               REG_CALF_LENGTH:  geom.calf_length <= pwdata[15:0];
               REG_FOOT_LENGTH:  geom.foot_length <= pwdata[15:0];
               REG_EFFORT_THR:   geom.effort_threshold <= pwdata[14:0];
               REG_CROUCH_FLOOR: geom.crouch_effort_floor <= pwdata[14:0];
               REG_CROUCH_DEPTH: geom.crouch_depth <= pwdata[15:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            foot_state_q.push_back(predict_foot_state());
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.pos_x, rsp_mon.pos_y, rsp_mon.pos_z, rsp_mon.vel_x,
                    rsp_mon.vel_y, rsp_mon.vel_z, rsp_mon.in_contact, rsp_mon.landing};
            results_seen <= results_seen + 1;
            contacts_seen <= contacts_seen + got.in_contact;
            landings_seen <= landings_seen + got.landing;
            if (foot_state_q.size() == 0) begin
               if (mismatches < 10) begin
                  $display("ERROR: unexpected foot state beat %p", got);
               end
               mismatches <= mismatches + 1;
            end else begin
               want = foot_state_q.pop_front();
               if (want !== got) begin
                  if (mismatches < 10) begin
                     $display("ERROR: foot state mismatch\n  expected %p\n  actual   %p",
                              want, got);
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/leg_kinematics_contact_detect_unit_test.sv =====
// Top of the leg kinematics testbench: clock, reset, joint sample stimulus,
// register writes and result back-pressure. Depends on lkcd_pkg, lkcd_if, the
// block itself and lkcd_foot_state_checker, which does all the checking.
`default_nettype none

module leg_kinematics_contact_detect_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lkcd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 12;
   // Register index past the end of the register list; writes there are ignored.
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

   typedef struct {
      logic [1:0]         leg;
      logic signed [15:0] angle [3];
      logic signed [15:0] rate [3];
      logic signed [15:0] effort;
   } joint_sample_type;

   logic clock, reset;
   logic psel, penable, pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;
   logic pready;
   int mismatches, outstanding, results_seen, contacts_seen, landings_seen;
   int samples_sent, cycles;
   logic [14:0] effort_thr, crouch_floor;

   lkcd_req_if req_if ();
   lkcd_rsp_if rsp_if ();

   leg_kinematics_contact_detect_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_if), .rsp_chan(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   lkcd_foot_state_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_if), .rsp_mon(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .mismatches(mismatches),
      .outstanding(outstanding), .results_seen(results_seen),
      .contacts_seen(contacts_seen), .landings_seen(landings_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAIL leg_kinematics_contact_detect_unit");
         $finish;
      end
   end

   // Receiver: ready is always high, random or mostly low, switching mode at random;
   // once, after enough beats went in, it holds off long enough for the pipeline to back up.
   initial begin
      int mode, hold_done;
      rsp_if.ready = 1'b0;
      hold_done = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && samples_sent >= 150) begin
            hold_done = 1;
            rsp_if.ready = 1'b0;
            repeat (80) @(negedge clock);
         end
         mode = $urandom_range(2);
         repeat ($urandom_range(60, 10)) begin
            case (mode)
               0: rsp_if.ready = 1'b1;
               1: rsp_if.ready = 1'($urandom_range(1));
               default: rsp_if.ready = ($urandom_range(4) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   task automatic send_sample(input joint_sample_type s);
      req_if.valid = 1'b1;
      req_if.leg = s.leg;
      req_if.hip_angle = s.angle[0];
      req_if.thigh_angle = s.angle[1];
      req_if.knee_angle = s.angle[2];
      req_if.hip_rate = s.rate[0];
      req_if.thigh_rate = s.rate[1];
      req_if.knee_rate = s.rate[2];
      req_if.foot_effort = s.effort;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic idle_input(input int n);
      req_if.valid = 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drained();
      idle_input(1);
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      if (idx == REG_EFFORT_THR) effort_thr = value[14:0];
      if (idx == REG_CROUCH_FLOOR) crouch_floor = value[14:0];
   endtask

   task automatic write_geometry(input logic [15:0] hip, thigh, calf, foot,
                                 input logic [14:0] thr, floor_v, input logic [15:0] depth);
      csr_write(REG_HIP_LENGTH, {16'hFFFF, hip});
      csr_write(REG_THIGH_LENGTH, 32'(thigh));
      csr_write(REG_CALF_LENGTH, 32'(calf));
      csr_write(REG_FOOT_LENGTH, 32'(foot));
      csr_write(REG_EFFORT_THR, 32'(thr));
      csr_write(REG_CROUCH_FLOOR, 32'(floor_v));
      csr_write(REG_CROUCH_DEPTH, 32'(depth));
   endtask

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'(signed'($urandom_range(400)) - 200);
         default: return 16'($urandom);
      endcase
   endfunction

   // Efforts cluster around the threshold and the crouch band so that contact,
   // landing and the crouch override all show up often.
   function automatic joint_sample_type random_sample();
      joint_sample_type s;
      s.leg = 2'($urandom_range(3));
      for (int j = 0; j < 3; j++) begin
         s.angle[j] = pick_value();
         s.rate[j] = pick_value();
      end
      case ($urandom_range(5))
         0: s.effort = 16'($urandom);
         1: s.effort = 16'(effort_thr) + 16'(signed'($urandom_range(4)) - 2);
         2, 3: s.effort = 16'(crouch_floor) +
                          16'($urandom_range(effort_thr > crouch_floor ?
                                             effort_thr - crouch_floor : 2));
         default: s.effort = $urandom_range(1) ? 16'(effort_thr) + 16'($urandom_range(3000))
                                               : 16'($urandom_range(2000));
      endcase
      return s;
   endfunction

   task automatic random_run(input int count);
      int burst;
      burst = 0;
      repeat (count) begin
         if (burst == 0) begin
            burst = $urandom_range(30, 1);
            if ($urandom_range(2) != 0) idle_input($urandom_range(8, 1));
         end
         burst--;
         send_sample(random_sample());
      end
   endtask

   initial begin
      joint_sample_type s;
      cycles = 0;
      samples_sent = 0;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      effort_thr = EFFORT_THR_RST;
      crouch_floor = CROUCH_FLOOR_RST;
      req_if.valid = 1'b0;
      req_if.leg = '0;
      req_if.hip_angle = '0;
      req_if.thigh_angle = '0;
      req_if.knee_angle = '0;
      req_if.hip_rate = '0;
      req_if.thigh_rate = '0;
      req_if.knee_rate = '0;
      req_if.foot_effort = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed beats: field extremes on every leg, effort at and around the
      // threshold, repeated contact on one leg, negative effort and a crouched pose.
      for (int k = 0; k < 8; k++) begin
         s.leg = k[1:0];
         for (int j = 0; j < 3; j++) begin
            s.angle[j] = k[2] ? 16'sh7FFF : 16'sh8000;
            s.rate[j] = k[0] ? 16'sh8000 : 16'sh7FFF;
         end
         s.effort = k[2] ? 16'sh7FFF : 16'sh8000;
         send_sample(s);
      end
      s.angle = '{16'sd0, 16'sd0, 16'sd0};
      s.rate = '{16'sd0, 16'sd0, 16'sd0};
      for (int k = 0; k < 4; k++) begin
         s.leg = 2'd2;
         s.effort = 16'(EFFORT_THR_RST) + 16'(k) - 16'sd1;
         send_sample(s);
      end
      s.leg = 2'd3;
      s.effort = 16'sd6000;
      send_sample(s);
      send_sample(s);
      s.effort = -16'sd6000;
      send_sample(s);
      s.angle = '{16'sd0, 16'sd8000, -16'sd16000};
      s.effort = 16'sd3000;
      for (int k = 0; k < 4; k++) begin
         s.leg = k[1:0];
         send_sample(s);
      end
      s.angle = '{16'sd12868, -16'sd25736, 16'sd25736};
      s.rate = '{16'sd1024, -16'sd1024, 16'sd512};
      send_sample(s);
      random_run(380);

      // Pause until the pipeline is empty, then sweep the register settings.
      wait_drained();
      write_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF, 16'hFFFF);
      csr_write(REG_UNMAPPED, 32'h1234);
      random_run(250);
      wait_drained();
      write_geometry('0, '0, '0, '0, '0, '0, '0);
      random_run(200);
      repeat (4) begin
         wait_drained();
         write_geometry(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom_range(8000)), 15'($urandom_range(9000)),
                        15'($urandom_range(4000)), 16'($urandom));
         random_run(120);
      end

      wait_drained();
      $display("covered %0d joint samples, %0d results, %0d in contact, %0d landings,",
               samples_sent, results_seen, contacts_seen, landings_seen);
      $display("over reset, all-ones, all-zero and random geometry settings");
      if (mismatches == 0) begin
         $display("PASS leg_kinematics_contact_detect_unit");
      end else begin
         $display("FAIL leg_kinematics_contact_detect_unit");
      end
      $finish;
   end

endmodule

`default_nettype wire
